### rtl/pfc_pkg.sv
package pfc_pkg;

    // Size codes; code three behaves as 32 bits
    localparam logic [1:0] SIZE_16 = 2'd0;
    localparam logic [1:0] SIZE_24 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_IN_SIZE     = 3'd0;
    localparam logic [2:0] CFG_IN_ALPHA    = 3'd1;
    localparam logic [2:0] CFG_IN_OVERLAY  = 3'd2;
    localparam logic [2:0] CFG_IN_BGR      = 3'd3;
    localparam logic [2:0] CFG_OUT_SIZE    = 3'd4;
    localparam logic [2:0] CFG_OUT_ALPHA   = 3'd5;
    localparam logic [2:0] CFG_OUT_OVERLAY = 3'd6;
    localparam logic [2:0] CFG_OUT_BGR     = 3'd7;

    localparam logic [31:0] MASK_16     = 32'h0000_ffff;
    localparam logic [31:0] MASK_24     = 32'h00ff_ffff;
    localparam logic [31:0] MASK_32     = 32'hffff_ffff;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;
    localparam logic [15:0] TOP16       = 16'h8000;
    localparam logic [15:0] SWAP16_KEEP = 16'b1000_0011_1110_0000;

    typedef struct packed {
        logic [1:0] in_size;
        logic       in_alpha;
        logic       in_overlay;
        logic       in_bgr;
        logic [1:0] out_size;
        logic       out_alpha;
        logic       out_overlay;
        logic       out_bgr;
    } cfg_t;

    // Fold size code three onto 32 bits
    function automatic logic [1:0] norm_size(input logic [1:0] s);
        logic [1:0] r;
        r = (s == SIZE_16) ? SIZE_16 : ((s == SIZE_24) ? SIZE_24 : SIZE_32);
        return r;
    endfunction

    function automatic logic [31:0] size_mask(input logic [1:0] s);
        logic [31:0] m;
        m = (s == SIZE_16) ? MASK_16 : ((s == SIZE_24) ? MASK_24 : MASK_32);
        return m;
    endfunction

endpackage

### rtl/pixel_format_converter.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    pixel_in[31:0], last_pixel
// output    out_valid / out_ready  pixel_out[31:0], last_out
// config    cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[1:0]
//
// One pixel per clock sustained while out_ready stays high. A request is held in
// the input register and is converted on its way into the result register,
// which drives out_valid. Reset (rst_n, async, low) empties both stages and
// loads 32-bit, no alpha, no overlay, red-high formats.
// A stalled output holds its request; the input stage keeps filling behind it
// and in_ready drops only while both registers hold a request and out_ready is low.
module pixel_format_converter (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pixel_in,
    input  logic        last_pixel,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_out,
    output logic        last_out,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    pfc_pkg::cfg_t cfg;

    // input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_pixel_reg;
    logic        s1_last_reg;

    // result stage
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic [31:0] s2_pixel_reg;
    logic        s2_last_reg;

    logic [31:0] conv_pixel;
    logic        s2_load;
    logic        s1_load;

    // Config always takes a write; software must write only when idle, unenforced
    assign cfg_ready = 1'b1;

    pfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfc_conv u_conv (
        .cfg    (cfg),
        .pixel  (s1_pixel_reg),
        .result (conv_pixel)
    );

    // Result stage loads a pending request when empty or being drained this cycle
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s2_load)
            s2_valid_next = 1'b1;
        else if (out_ready)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pixel_reg <= pixel_in;
            s1_last_reg  <= last_pixel;
        end
        if (s2_load)
        begin
            s2_pixel_reg <= conv_pixel;
            s2_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign pixel_out = s2_pixel_reg;
    assign last_out  = s2_last_reg;

`ifndef SYNTHESIS
    // An empty input stage never refuses a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but in_ready low");

    // An accepted request sits in the input stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request lost from input stage");

    // A pending request moves on once the result stage has room
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (!s2_valid_reg || out_ready) |=> out_valid)
        else $error("request did not reach result stage");
`endif

endmodule

### rtl/pfc_cfg.sv
module pfc_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    output pfc_pkg::cfg_t     cfg
);

    pfc_pkg::cfg_t cfg_reg;
    pfc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pfc_pkg::CFG_IN_SIZE:     cfg_next.in_size     = cfg_data;
                pfc_pkg::CFG_IN_ALPHA:    cfg_next.in_alpha    = cfg_data[0];
                pfc_pkg::CFG_IN_OVERLAY:  cfg_next.in_overlay  = cfg_data[0];
                pfc_pkg::CFG_IN_BGR:      cfg_next.in_bgr      = cfg_data[0];
                pfc_pkg::CFG_OUT_SIZE:    cfg_next.out_size    = cfg_data;
                pfc_pkg::CFG_OUT_ALPHA:   cfg_next.out_alpha   = cfg_data[0];
                pfc_pkg::CFG_OUT_OVERLAY: cfg_next.out_overlay = cfg_data[0];
                pfc_pkg::CFG_OUT_BGR:     cfg_next.out_bgr     = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{in_size: pfc_pkg::SIZE_32, in_alpha: 1'b0, in_overlay: 1'b0,
                         in_bgr: 1'b0, out_size: pfc_pkg::SIZE_32, out_alpha: 1'b0,
                         out_overlay: 1'b0, out_bgr: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pfc_conv.sv
module pfc_conv (
    input  pfc_pkg::cfg_t  cfg,
    input  logic [31:0]    pixel,
    output logic [31:0]    result
);

    logic [1:0]  si;
    logic [1:0]  so;
    logic [31:0] c;
    logic        same;
    logic        swap;
    logic [31:0] wide;
    logic [15:0] narrow;
    logic [15:0] narrow_sw;
    logic [31:0] up;
    logic [7:0]  up_hi, up_g, up_lo, up_r, up_b;
    logic        up_ov;
    logic [15:0] down;
    logic [4:0]  dn_hi, dn_g, dn_lo, dn_r, dn_b;
    logic        dn_top;
    logic [31:0] o;

    assign si   = pfc_pkg::norm_size(cfg.in_size);
    assign so   = pfc_pkg::norm_size(cfg.out_size);
    assign c    = pixel & pfc_pkg::size_mask(si);
    assign swap = cfg.in_bgr != cfg.out_bgr;
    assign same = (si == so) && (cfg.in_alpha == cfg.out_alpha)
                  && (cfg.in_overlay == cfg.out_overlay) && !swap;

    // 24/32 <-> 24/32: alpha fix-up then red/blue byte swap
    always_comb
    begin
        wide = c;
        if (!cfg.in_alpha && cfg.out_alpha)
            wide = wide | pfc_pkg::ALPHA_OPAQUE;
        if (cfg.in_alpha && !cfg.out_alpha)
            wide = wide & pfc_pkg::MASK_24;
        if (swap)
            wide = {wide[31:24], wide[7:0], wide[15:8], wide[23:16]};
    end

    // 16 <-> 16: top bit meaning changes, then 5-bit red/blue swap
    always_comb
    begin
        narrow = c[15:0];
        priority if (cfg.in_alpha)
        begin
            if (cfg.out_overlay)
                narrow = narrow ^ pfc_pkg::TOP16;
        end
        else if (cfg.in_overlay)
        begin
            if (cfg.out_alpha)
                narrow = narrow ^ pfc_pkg::TOP16;
        end
        else
        begin
            if (cfg.out_alpha)
                narrow = narrow | pfc_pkg::TOP16;
            else if (cfg.out_overlay)
                narrow = narrow & ~pfc_pkg::TOP16;
        end
        narrow_sw = (narrow & pfc_pkg::SWAP16_KEEP)
                    | {11'd0, narrow[14:10]} | {1'b0, narrow[4:0], 10'd0};
        if (!swap)
            narrow_sw = narrow;
    end

    // 16 -> 24/32
    always_comb
    begin
        up_ov = cfg.in_overlay && c[15];
        up_hi = {c[14:10], 3'b000};
        up_g  = {c[9:5], 3'b000};
        up_lo = {c[4:0], 3'b000};
        up_r  = cfg.in_bgr ? up_lo : up_hi;
        up_b  = cfg.in_bgr ? up_hi : up_lo;
        up    = cfg.out_bgr ? {8'd0, up_b, up_g, up_r} : {8'd0, up_r, up_g, up_b};
        if (cfg.out_alpha && !up_ov)
            up = up | pfc_pkg::ALPHA_OPAQUE;
    end

    // 24/32 -> 16: truncate channels, alpha bit 7 to the top bit (inverted for overlay)
    always_comb
    begin
        dn_top = 1'b0;
        if (cfg.in_alpha && cfg.out_overlay)
            dn_top = !c[31];
        else if (cfg.in_alpha && cfg.out_alpha)
            dn_top = c[31];
        dn_hi = c[23:19];
        dn_g  = c[15:11];
        dn_lo = c[7:3];
        dn_r  = cfg.in_bgr ? dn_lo : dn_hi;
        dn_b  = cfg.in_bgr ? dn_hi : dn_lo;
        down  = cfg.out_bgr ? {dn_top, dn_b, dn_g, dn_r} : {dn_top, dn_r, dn_g, dn_b};
    end

    always_comb
    begin
        priority if (same)
            o = c;
        else if ((si != pfc_pkg::SIZE_16) && (so != pfc_pkg::SIZE_16))
            o = wide;
        else if ((si == pfc_pkg::SIZE_16) && (so == pfc_pkg::SIZE_16))
            o = {16'd0, narrow_sw};
        else if (si == pfc_pkg::SIZE_16)
            o = up;
        else
            o = {16'd0, down};
    end

    assign result = o & pfc_pkg::size_mask(so);

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Size code three is an alias of 32 bits; the package names only 0..2
    localparam logic [1:0] SIZE_32_ALT = 2'd3;

    // Order in which a full format is written to the register file
    localparam logic [2:0] REG_ORDER [8] = '{
        pfc_pkg::CFG_IN_SIZE, pfc_pkg::CFG_IN_ALPHA,
        pfc_pkg::CFG_IN_OVERLAY, pfc_pkg::CFG_IN_BGR,
        pfc_pkg::CFG_OUT_SIZE, pfc_pkg::CFG_OUT_ALPHA,
        pfc_pkg::CFG_OUT_OVERLAY, pfc_pkg::CFG_OUT_BGR
    };

    typedef struct {
        logic [31:0] pixel;
        logic        last;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] pixel_in = '0;
    logic        last_pixel = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] pixel_out;
    logic        last_out;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = pfc_pkg::CFG_IN_SIZE;
    logic [1:0]  cfg_data = '0;

    // Format the converter holds right now, tracked from accepted writes.
    // Starts at the reset format: 32 -> 32, no flags.
    pfc_pkg::cfg_t active_fmt = '{in_size: pfc_pkg::SIZE_32, in_alpha: 1'b0,
                                  in_overlay: 1'b0, in_bgr: 1'b0,
                                  out_size: pfc_pkg::SIZE_32, out_alpha: 1'b0,
                                  out_overlay: 1'b0, out_bgr: 1'b0};
    pixel_result_t converted_q[$];   // expected conversions, oldest first
    int            error_count = 0;

    // Idle percentages for the current phase
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    pixel_format_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .last_pixel (last_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .last_out   (last_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] bytes_mask(input logic [1:0] sz);
        case (sz)
            pfc_pkg::SIZE_16: return 32'h0000_ffff;
            pfc_pkg::SIZE_24: return 32'h00ff_ffff;
            default:          return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [31:0] predict_pixel(input pfc_pkg::cfg_t f,
                                                  input logic [31:0] raw);
        logic [1:0]  si;
        logic [1:0]  so;
        logic [31:0] c;
        logic [31:0] o;
        logic        ov;
        logic [7:0]  hi8, grn8, lo8, red8, blu8;
        logic [4:0]  hi5, grn5, lo5, red5, blu5;
        // code three folds onto 32 bits
        si = (f.in_size == pfc_pkg::SIZE_16 || f.in_size == pfc_pkg::SIZE_24)
             ? f.in_size : pfc_pkg::SIZE_32;
        so = (f.out_size == pfc_pkg::SIZE_16 || f.out_size == pfc_pkg::SIZE_24)
             ? f.out_size : pfc_pkg::SIZE_32;
        c = raw & bytes_mask(si);
        o = '0;
        if (si == so && f.in_alpha == f.out_alpha && f.in_overlay == f.out_overlay
            && f.in_bgr == f.out_bgr)
        begin
            o = c;
        end
        else if (si != pfc_pkg::SIZE_16 && so != pfc_pkg::SIZE_16)
        begin
            // 24/32 <-> 24/32: alpha byte handling, then red/blue byte swap
            if (!f.in_alpha && f.out_alpha)
                c[31:24] = 8'hff;
            if (f.in_alpha && !f.out_alpha)
                c[31:24] = 8'h00;
            if (f.in_bgr != f.out_bgr)
                c = {c[31:24], c[7:0], c[15:8], c[23:16]};
            o = c;
        end
        else if (si == pfc_pkg::SIZE_16 && so == pfc_pkg::SIZE_16)
        begin
            // alpha wins over overlay when both flags are set
            if (f.in_alpha)
            begin
                if (f.out_overlay)
                    c[15] = ~c[15];
            end
            else if (f.in_overlay)
            begin
                if (f.out_alpha)
                    c[15] = ~c[15];
            end
            else if (f.out_alpha)
                c[15] = 1'b1;
            else if (f.out_overlay)
                c[15] = 1'b0;
            if (f.in_bgr != f.out_bgr)
                c[14:0] = {c[4:0], c[9:5], c[14:10]};
            o = c;
        end
        else if (si == pfc_pkg::SIZE_16)
        begin
            // 5-bit channels widen by shifting left 3; marked overlay stays clear
            ov = f.in_overlay && c[15];
            hi8 = {c[14:10], 3'b000};
            grn8 = {c[9:5], 3'b000};
            lo8 = {c[4:0], 3'b000};
            red8 = f.in_bgr ? lo8 : hi8;
            blu8 = f.in_bgr ? hi8 : lo8;
            o = f.out_bgr ? {8'h00, blu8, grn8, red8} : {8'h00, red8, grn8, blu8};
            if (f.out_alpha && !ov)
                o[31:24] = 8'hff;
        end
        else
        begin
            // truncate to top 5 bits per channel; alpha bit 7 maps to bit 15
            if (f.in_alpha && f.out_overlay)
                o[15] = ~c[31];
            else if (f.in_alpha && f.out_alpha)
                o[15] = c[31];
            hi5 = c[23:19];
            grn5 = c[15:11];
            lo5 = c[7:3];
            red5 = f.in_bgr ? lo5 : hi5;
            blu5 = f.in_bgr ? hi5 : lo5;
            o[14:0] = f.out_bgr ? {blu5, grn5, red5} : {red5, grn5, blu5};
        end
        return o & bytes_mask(so);
    endfunction

    function automatic pfc_pkg::cfg_t make_format(input logic [1:0] isz, input logic ia,
                                                  input logic io, input logic ib,
                                                  input logic [1:0] osz, input logic oa,
                                                  input logic oo, input logic ob);
        pfc_pkg::cfg_t f;
        f.in_size = isz;
        f.in_alpha = ia;
        f.in_overlay = io;
        f.in_bgr = ib;
        f.out_size = osz;
        f.out_alpha = oa;
        f.out_overlay = oo;
        f.out_bgr = ob;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random backpressure and result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (recv_stall_pct == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Every accepted result is held against the oldest pending conversion
    always @(posedge clk)
    begin : check_results
        pixel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (converted_q.size() == 0)
                report_mismatch("unexpected result", pixel_out, '0);
            else
            begin
                want = converted_q.pop_front();
                if (pixel_out !== want.pixel)
                    report_mismatch("pixel_out", pixel_out, want.pixel);
                if (last_out !== want.last)
                    report_mismatch("last_out", {31'd0, last_out}, {31'd0, want.last});
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one pixel and hold it until accepted. Valid stays high afterward
    // unless an idle gap is taken, so back-to-back calls stream with no bubble.
    task automatic send_pixel(input logic [31:0] pix, input logic last);
        pixel_result_t want;
        in_valid <= 1'b1;
        pixel_in <= pix;
        last_pixel <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want.pixel = predict_pixel(active_fmt, pix);
        want.last = last;
        converted_q.push_back(want);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // Drop valid and wait for every pending conversion to come out
    task automatic drain_stream();
        in_valid <= 1'b0;
        @(posedge clk);
        while (converted_q.size() != 0)
            @(posedge clk);
    endtask

    // Write all eight registers. Only done with the pipeline empty, since a
    // change would otherwise hit requests already inside the block.
    task automatic set_format(input pfc_pkg::cfg_t f);
        logic [2:0] idx;
        logic [1:0] val;
        drain_stream();
        repeat (3)
            @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            idx = REG_ORDER[i];
            // flag registers use bit 0; bit 1 is random junk they must ignore
            val = {1'($urandom_range(1)), 1'b0};
            case (idx)
                pfc_pkg::CFG_IN_SIZE:     val = f.in_size;
                pfc_pkg::CFG_IN_ALPHA:    val[0] = f.in_alpha;
                pfc_pkg::CFG_IN_OVERLAY:  val[0] = f.in_overlay;
                pfc_pkg::CFG_IN_BGR:      val[0] = f.in_bgr;
                pfc_pkg::CFG_OUT_SIZE:    val = f.out_size;
                pfc_pkg::CFG_OUT_ALPHA:   val[0] = f.out_alpha;
                pfc_pkg::CFG_OUT_OVERLAY: val[0] = f.out_overlay;
                default:                  val[0] = f.out_bgr;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                pfc_pkg::CFG_IN_SIZE:     active_fmt.in_size = val;
                pfc_pkg::CFG_IN_ALPHA:    active_fmt.in_alpha = val[0];
                pfc_pkg::CFG_IN_OVERLAY:  active_fmt.in_overlay = val[0];
                pfc_pkg::CFG_IN_BGR:      active_fmt.in_bgr = val[0];
                pfc_pkg::CFG_OUT_SIZE:    active_fmt.out_size = val;
                pfc_pkg::CFG_OUT_ALPHA:   active_fmt.out_alpha = val[0];
                pfc_pkg::CFG_OUT_OVERLAY: active_fmt.out_overlay = val[0];
                default:                  active_fmt.out_bgr = val[0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset format is 32 -> 32 with no flags: plain pass-through
    task automatic test_reset_passthrough();
        send_pixel(32'hffff_ffff, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
    endtask

    // One asymmetric pattern (distinct channels, bit 31 and bit 15 clear)
    // and all ones per format, so swaps and top-bit handling show up.
    task automatic test_directed_formats();
        pfc_pkg::cfg_t fmts [8];
        // 16 alpha -> 16 overlay, channel order flipped
        fmts[0] = make_format(pfc_pkg::SIZE_16, 1'b1, 1'b0, 1'b0,
                              pfc_pkg::SIZE_16, 1'b0, 1'b1, 1'b1);
        // 16 plain -> 16 alpha: top bit forced high
        fmts[1] = make_format(pfc_pkg::SIZE_16, 1'b0, 1'b0, 1'b1,
                              pfc_pkg::SIZE_16, 1'b1, 1'b0, 1'b1);
        // 16 plain -> 16 overlay: top bit cleared
        fmts[2] = make_format(pfc_pkg::SIZE_16, 1'b0, 1'b0, 1'b0,
                              pfc_pkg::SIZE_16, 1'b0, 1'b1, 1'b0);
        // 16 overlay -> 32 alpha bgr: marked pixels stay transparent
        fmts[3] = make_format(pfc_pkg::SIZE_16, 1'b0, 1'b1, 1'b0,
                              pfc_pkg::SIZE_32, 1'b1, 1'b0, 1'b1);
        // 32 alpha -> 16 overlay: alpha bit 7 inverted onto top bit
        fmts[4] = make_format(pfc_pkg::SIZE_32, 1'b1, 1'b0, 1'b1,
                              pfc_pkg::SIZE_16, 1'b0, 1'b1, 1'b0);
        // 24 -> alias size code with alpha: opaque byte added
        fmts[5] = make_format(pfc_pkg::SIZE_24, 1'b0, 1'b0, 1'b0,
                              SIZE_32_ALT, 1'b1, 1'b0, 1'b0);
        // alpha and overlay both set on input and on output, 32 -> 16
        fmts[6] = make_format(SIZE_32_ALT, 1'b1, 1'b1, 1'b0,
                              pfc_pkg::SIZE_16, 1'b1, 1'b1, 1'b1);
        // alpha flag on a 24-bit input reads as a zero alpha byte
        fmts[7] = make_format(pfc_pkg::SIZE_24, 1'b1, 1'b0, 1'b1,
                              pfc_pkg::SIZE_16, 1'b1, 1'b0, 1'b0);
        foreach (fmts[i])
        begin
            set_format(fmts[i]);
            send_pixel(32'h00f8_7c07, 1'b0);
            send_pixel(32'hffff_ffff, 1'b1);
        end
    endtask

    // Stream, stop until everything is out, then resume with a new stream
    task automatic test_drain_and_resume();
        for (int i = 0; i < 6; i++)
            send_pixel($urandom, 1'($urandom_range(1)));
        drain_stream();
        for (int i = 0; i < 6; i++)
            send_pixel($urandom, 1'($urandom_range(1)));
    endtask

    // Random formats, each held for a burst of random pixels
    task automatic test_random_formats(input int n_pixels);
        pfc_pkg::cfg_t f;
        int            burst;
        logic [31:0]   pix;
        while (n_pixels > 0)
        begin
            f = make_format(2'($urandom_range(3)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            2'($urandom_range(3)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
            set_format(f);
            burst = $urandom_range(15, 40);
            for (int i = 0; i < burst; i++)
            begin
                case ($urandom_range(9))
                    0:       pix = 32'hffff_ffff;
                    1:       pix = 32'h0000_0000;
                    default: pix = $urandom;
                endcase
                send_pixel(pix, ($urandom_range(7) == 0));
            end
            n_pixels -= burst;
        end
    endtask

    // Safety net against a hung handshake
    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_passthrough();
        test_directed_formats();
        test_drain_and_resume();

        // idling phases: none, sender gaps, receiver stalls, both lightly
        test_random_formats(170);
        send_idle_pct = 46;
        test_random_formats(170);
        send_idle_pct = 0;
        recv_stall_pct = 46;
        test_random_formats(170);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        test_random_formats(170);

        drain_stream();
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/pfc_pkg.sv
rtl/pfc_cfg.sv
rtl/pfc_conv.sv
rtl/pixel_format_converter.sv
tb/tb_top.sv
